/* rtl/core/allocation_usage_lifetime_tracker_assert.svh */
// Assertion macros used by the checker of the allocation tracker.
// Depends on nothing; included by the checker file.
`ifndef ALLOCATION_USAGE_LIFETIME_TRACKER_ASSERT_SVH
`define ALLOCATION_USAGE_LIFETIME_TRACKER_ASSERT_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define AULT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Same, for modules whose clock and reset are named i_clk and i_rst_n.
`define AULT_ASSERT_STD(lbl, prop, msg) \
    `AULT_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* rtl/core/ault_pkg.sv */
// Types and constants of the allocation usage and lifetime tracker.
// Depends on nothing; used by the top level and its checker.
package ault_pkg;

    // Event kinds.
    localparam logic MODE_CREATE  = 1'b0;
    localparam logic MODE_DESTROY = 1'b1;

    // Result status codes.
    localparam logic [1:0] STS_CREATED   = 2'd0;
    localparam logic [1:0] STS_MATCHED   = 2'd1;
    localparam logic [1:0] STS_UNMATCHED = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    // One input word.
    typedef struct packed {
        logic        mode;
        logic [63:0] block_id;
        logic [31:0] length;
        logic [47:0] event_time;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] usage_bytes;
        logic [47:0] lifetime;
    } t_out_word;

    // One table entry as held in the entry RAM.
    typedef struct packed {
        logic        valid;
        logic [63:0] id;
        logic [31:0] length;
        logic [47:0] birth;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_SUB_TOTAL,
        ST_SUB_LIFE,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/ault_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ault_ram #(
    parameter int WIDTH = 145,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/allocation_usage_lifetime_tracker.sv */
// Top level of the allocation usage and lifetime tracker: sequencer, shared adder
// and the entry table. Depends on ault_pkg and ault_ram.
//
//   channel  direction  handshake                 word
//   input    in         i_in_valid / o_in_ready   i_in_data  (t_in_word)
//   result   out        o_out_valid / i_out_ready o_out_data (t_out_word)
//
// A create scans the table from index 0 and stops at the lowest free slot; a
// full table, an unmatched destroy and a matched destroy scan every entry. The
// scan is paced by the single read port of the entry RAM, read one entry per
// cycle, with one shared 48-bit adder doing the birth compare, the total update
// and the lifetime. After reset a clearing pass writes every entry invalid; no
// word is accepted meanwhile. A stalled result holds the sequencer in its
// final state until the result register is free.
module allocation_usage_lifetime_tracker
    import ault_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // Control registers.
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_rd_more, n_rd_more;
    logic          r_chk_pend, n_chk_pend;
    logic          r_found, n_found;
    logic          r_out_valid, n_out_valid;
    logic [47:0]   r_total, n_total;

    // Payload registers.
    t_in_word      r_in, n_in;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [47:0]   r_best_birth, n_best_birth;
    logic [31:0]   r_best_len, n_best_len;
    logic [AW-1:0] r_free_idx, n_free_idx;
    logic [1:0]    r_res_status, n_res_status;
    logic [47:0]   r_res_life, n_res_life;
    t_out_word     r_out, n_out;

    // Entry RAM ports.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;
    logic               id_hit;

    // Shared adder / subtractor.
    logic [47:0] add_a, add_b;
    logic        add_sub;
    logic [48:0] add_sum;
    logic        add_carry;

    ault_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign id_hit   = rd_entry.valid && (rd_entry.id == r_in.block_id);

    // The one arithmetic unit: a + b, or a - b with carry meaning no borrow.
    assign add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 49'(add_sub);
    assign add_carry = add_sum[48];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Next state, RAM control and adder operands.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_rd_more    = r_rd_more;
        n_chk_pend   = r_chk_pend;
        n_found      = r_found;
        n_total      = r_total;
        n_in         = r_in;
        n_rd_addr    = r_rd_addr;
        n_chk_addr   = r_chk_addr;
        n_best_idx   = r_best_idx;
        n_best_birth = r_best_birth;
        n_best_len   = r_best_len;
        n_free_idx   = r_free_idx;
        n_res_status = r_res_status;
        n_res_life   = r_res_life;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_rd_addr;

        add_a   = r_total;
        add_b   = {16'b0, r_in.length};
        add_sub = 1'b0;

        unique case (r_state)
            // Write every entry invalid once after reset.
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end

            // Take one word and start the table scan.
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in       = i_in_data;
                    n_rd_addr  = '0;
                    n_rd_more  = 1'b1;
                    n_chk_pend = 1'b0;
                    n_found    = 1'b0;
                    n_state    = ST_SCAN;
                end
            end

            // Issue one read per cycle and check the entry read the cycle before.
            ST_SCAN: begin
                if (r_rd_more) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_rd_addr;
                    n_chk_pend = 1'b1;
                    n_chk_addr = r_rd_addr;
                    if (r_rd_addr == LAST_IDX) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + 1'b1;
                    end
                end else begin
                    n_chk_pend = 1'b0;
                end

                if (r_chk_pend) begin
                    if (r_in.mode == MODE_CREATE) begin
                        // First free slot wins.
                        if (!rd_entry.valid) begin
                            n_free_idx = r_chk_addr;
                            n_rd_more  = 1'b0;
                            n_chk_pend = 1'b0;
                            n_state    = ST_ADD;
                        end else if (r_chk_addr == LAST_IDX) begin
                            n_res_status = STS_FULL;
                            n_res_life   = '0;
                            n_state      = ST_DONE;
                        end
                    end else begin
                        // Keep the oldest hit; equal births keep the lower index.
                        add_a   = rd_entry.birth;
                        add_b   = r_best_birth;
                        add_sub = 1'b1;
                        if (id_hit && (!r_found || !add_carry)) begin
                            n_found      = 1'b1;
                            n_best_idx   = r_chk_addr;
                            n_best_birth = rd_entry.birth;
                            n_best_len   = rd_entry.length;
                        end
                        if (r_chk_addr == LAST_IDX) begin
                            if (r_found || id_hit) begin
                                n_state = ST_SUB_TOTAL;
                            end else begin
                                n_res_status = STS_UNMATCHED;
                                n_res_life   = '0;
                                n_state      = ST_DONE;
                            end
                        end
                    end
                end
            end

            // Store the new entry and add its length, saturating.
            ST_ADD: begin
                ram_we    = 1'b1;
                ram_waddr = r_free_idx;
                ram_wdata = '{valid: 1'b1, id: r_in.block_id,
                              length: r_in.length, birth: r_in.event_time};
                add_a   = r_total;
                add_b   = {16'b0, r_in.length};
                add_sub = 1'b0;
                n_total = add_carry ? '1 : add_sum[47:0];
                n_res_status = STS_CREATED;
                n_res_life   = '0;
                n_state      = ST_DONE;
            end

            // Free the matched entry and take its length off, floored at zero.
            ST_SUB_TOTAL: begin
                ram_we    = 1'b1;
                ram_waddr = r_best_idx;
                ram_wdata = '0;
                add_a   = r_total;
                add_b   = {16'b0, r_best_len};
                add_sub = 1'b1;
                n_total = add_carry ? add_sum[47:0] : '0;
                n_state = ST_SUB_LIFE;
            end

            // Lifetime, zero when time went backwards.
            ST_SUB_LIFE: begin
                add_a   = r_in.event_time;
                add_b   = r_best_birth;
                add_sub = 1'b1;
                n_res_life   = add_carry ? add_sum[47:0] : '0;
                n_res_status = STS_MATCHED;
                n_state      = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_res_status;
                    n_out.usage_bytes = r_total;
                    n_out.lifetime    = r_res_life;
                    n_state           = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_more   <= 1'b0;
            r_chk_pend  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_more   <= n_rd_more;
            r_chk_pend  <= n_chk_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_rd_addr    <= n_rd_addr;
        r_chk_addr   <= n_chk_addr;
        r_best_idx   <= n_best_idx;
        r_best_birth <= n_best_birth;
        r_best_len   <= n_best_len;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_res_life   <= n_res_life;
        r_out        <= n_out;
    end

endmodule

/* rtl/core/ault_checker.sv */
// Port-level checker of the allocation usage and lifetime tracker, with its bind.
// Depends on ault_pkg and the assertion macro header.
`include "allocation_usage_lifetime_tracker_assert.svh"

module ault_checker
    import ault_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // A stalled result word holds.
    `AULT_ASSERT_STD(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "result word changed while stalled")

    // One word at a time: ready drops right after an accept.
    `AULT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, in_acc |=> !o_in_ready, "word accepted while busy")

    // Only a matched destroy reports a lifetime.
    `AULT_ASSERT_STD(a_life_only_on_match, (o_out_valid && (o_out_data.status != STS_MATCHED)) |-> (o_out_data.lifetime == 48'd0), "lifetime without a match")

    // A result never appears in the cycle right after an accept with no word waiting.
    `AULT_ASSERT_STD(a_no_instant_result, (in_acc && !o_out_valid) |=> !o_out_valid, "result ahead of its scan")

endmodule

bind allocation_usage_lifetime_tracker ault_checker u_ault_checker (.*);

/* test/tb.sv */
// Self-checking testbench for the allocation usage and lifetime tracker.
// Depends on ault_pkg and the allocation_usage_lifetime_tracker RTL; holds its
// own table model, drives both channels with random gaps and checks each result word.
`timescale 1ns / 1ps

module tb;
    import ault_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int ID_POOL = 12;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int IDLE_LIMIT = 8000;
    localparam int HOLD_OFF = 1500;
    localparam int HOLD_AFTER = 150;
    localparam int MAX_REPORTS = 10;

    // Table model: predicts the result word of every accepted event and checks
    // the result words against those predictions in order.
    class alloc_ledger;
        bit          live_valid [TABLE_DEPTH];
        bit [63:0]   live_id [TABLE_DEPTH];
        bit [31:0]   live_len [TABLE_DEPTH];
        bit [47:0]   live_birth [TABLE_DEPTH];
        bit [47:0]   usage_total;
        t_out_word   expected_reports [$];
        int          failures;
        int          reports_seen;
        int          n_created, n_matched, n_unmatched, n_full, n_backwards;

        function new();
            foreach (live_valid[k]) live_valid[k] = 1'b0;
            usage_total = '0;
            failures = 0;
            reports_seen = 0;
            n_created = 0;
            n_matched = 0;
            n_unmatched = 0;
            n_full = 0;
            n_backwards = 0;
        endfunction

        // Work out the result word of one accepted event and update the table.
        function void note_event(t_in_word w);
            t_out_word  r;
            int         slot;
            int         k;
            bit [48:0]  sum;
            r = '0;
            slot = -1;
            if (w.mode == MODE_CREATE) begin
                // A create takes the lowest free slot.
                for (k = 0; k < TABLE_DEPTH; k++) begin
                    if (!live_valid[k]) begin
                        slot = k;
                        break;
                    end
                end
                if (slot < 0) begin
                    r.status = STS_FULL;
                    n_full++;
                end else begin
                    live_valid[slot] = 1'b1;
                    live_id[slot] = w.block_id;
                    live_len[slot] = w.length;
                    live_birth[slot] = w.event_time;
                    sum = {1'b0, usage_total} + 49'(w.length);
                    usage_total = sum[48] ? '1 : sum[47:0];
                    r.status = STS_CREATED;
                    n_created++;
                end
            end else begin
                // A destroy frees the live entry of that id with the oldest birth;
                // on equal births the lower index wins.
                for (k = 0; k < TABLE_DEPTH; k++) begin
                    if (live_valid[k] && live_id[k] == w.block_id) begin
                        if (slot < 0 || live_birth[k] < live_birth[slot]) slot = k;
                    end
                end
                if (slot < 0) begin
                    r.status = STS_UNMATCHED;
                    n_unmatched++;
                end else begin
                    usage_total = (usage_total >= 48'(live_len[slot]))
                                ? usage_total - 48'(live_len[slot]) : '0;
                    if (w.event_time >= live_birth[slot]) begin
                        r.lifetime = w.event_time - live_birth[slot];
                    end else begin
                        n_backwards++;
                    end
                    live_valid[slot] = 1'b0;
                    r.status = STS_MATCHED;
                    n_matched++;
                end
            end
            r.usage_bytes = usage_total;
            expected_reports.push_back(r);
        endfunction

        function void flag_field(string field, bit [47:0] want, bit [47:0] got);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("Mismatch in result word %0d, %s: expected %h, got %h",
                         reports_seen, field, want, got);
            end
        endfunction

        // Compare one accepted result word with the oldest prediction.
        function void check_report(t_out_word got);
            t_out_word want;
            if (expected_reports.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("Result word %0d arrived with nothing expected: %h",
                             reports_seen, got);
                end
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status)
                    flag_field("status", 48'(want.status), 48'(got.status));
                if (got.usage_bytes !== want.usage_bytes)
                    flag_field("usage_bytes", want.usage_bytes, got.usage_bytes);
                if (got.lifetime !== want.lifetime)
                    flag_field("lifetime", want.lifetime, got.lifetime);
            end
            reports_seen++;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_word   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_word  out_data;

    alloc_ledger ledger;
    bit [63:0]   id_pool [ID_POOL];
    bit [47:0]   clock_now;
    bit          sender_quiet;
    bit          receiver_quiet;
    int          events_sent;
    int          idle_cycles;
    int          create_pct [0:PHASES-1] = '{80, 40, 100, 20, 60, 100, 10, 50, 85, 30, 70,
                                             100, 5};

    allocation_usage_lifetime_tracker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    always #4 clk = ~clk;

    // Watchdog: the run ends when no word moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_word make_event(logic mode, bit [63:0] id, bit [31:0] len,
                                            bit [47:0] stamp);
        t_in_word w;
        w.mode = mode;
        w.block_id = id;
        w.length = len;
        w.event_time = stamp;
        return w;
    endfunction

    // Offer one event word, called at a falling edge; returns at the falling
    // edge after the word was accepted, with valid still high.
    task automatic send_event(t_in_word w);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ledger.note_event(w);
        events_sent++;
        @(negedge clk);
    endtask

    // One random event: mostly ids from a small pool so that destroys find
    // their entries, with a share of random ids and out-of-order times.
    task automatic send_random_event(int pct);
        t_in_word w;
        w.mode = ($urandom_range(0, 99) < pct) ? MODE_CREATE : MODE_DESTROY;
        if ($urandom_range(0, 9) == 0) begin
            w.block_id = {$urandom, $urandom};
        end else begin
            w.block_id = id_pool[$urandom_range(0, ID_POOL - 1)];
        end
        if ($urandom_range(0, 3) == 0) begin
            w.length = $urandom;
        end else begin
            w.length = $urandom_range(0, 4096);
        end
        if ($urandom_range(0, 19) == 0) begin
            w.event_time = 48'({$urandom, $urandom});
        end else begin
            clock_now = clock_now + 48'($urandom_range(0, 5000));
            w.event_time = clock_now;
        end
        send_event(w);
    endtask

    // Directed events: field extremes, equal births, oldest match, slot reuse,
    // time running backwards and unmatched destroys.
    task automatic run_directed();
        send_event(make_event(MODE_DESTROY, 64'h0, 32'h0, 48'h0));
        send_event(make_event(MODE_CREATE, '1, '1, 48'h0));
        send_event(make_event(MODE_CREATE, '1, 32'h0, 48'h0));
        send_event(make_event(MODE_DESTROY, '1, 32'h0, '1));
        send_event(make_event(MODE_DESTROY, '1, '1, 48'h0));
        send_event(make_event(MODE_DESTROY, '1, 32'h0, 48'h10));
        send_event(make_event(MODE_CREATE, 64'h1, 32'd100, 48'd1000));
        send_event(make_event(MODE_DESTROY, 64'h1, 32'h0, 48'd10));
        send_event(make_event(MODE_CREATE, 64'hA5A5, 32'd7, 48'd500));
        send_event(make_event(MODE_CREATE, 64'hA5A5, 32'd9, 48'd100));
        send_event(make_event(MODE_CREATE, 64'h5A5A, 32'd3, 48'd600));
        send_event(make_event(MODE_DESTROY, 64'hA5A5, 32'h0, 48'd700));
        send_event(make_event(MODE_CREATE, 64'h77, 32'd1, 48'd800));
        send_event(make_event(MODE_DESTROY, 64'hA5A5, 32'h0, 48'd900));
        send_event(make_event(MODE_DESTROY, 64'h77, 32'h0, 48'd801));
        send_event(make_event(MODE_DESTROY, 64'h5A5A, 32'h0, 48'h8000_0000_0000));
        send_event(make_event(MODE_CREATE, 64'h8000_0000_0000_0000, 32'h8000_0000,
                              48'h7FFF_FFFF_FFFF));
        send_event(make_event(MODE_DESTROY, 64'h8000_0000_0000_0000, 32'h0, '1));
    endtask

    // Result side: random ready gaps, quiet stretches, and one long hold-off
    // that lets the block back up and stall its input.
    initial begin
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (!held && ledger.reports_seen == HOLD_AFTER) begin
                gap = HOLD_OFF;
                held = 1'b1;
            end else begin
                if (ledger.reports_seen % 40 == 0) receiver_quiet = $urandom_range(0, 2) == 0;
                gap = receiver_quiet ? 0 : $urandom_range(0, 5);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            ledger.check_report(out_data);
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed events, random phases, drain and verdict.
    initial begin
        int p;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        idle_cycles = 0;
        events_sent = 0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        clock_now = 48'd2000;
        ledger = new();
        foreach (id_pool[k]) id_pool[k] = {$urandom, $urandom};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // Phases vary the share of creates between filling and draining the table.
        for (p = 0; p < PHASES; p++) begin
            sender_quiet = (p % 3 == 1);
            for (n = 0; n < PHASE_ITEMS; n++) send_random_event(create_pct[p]);
        end
        in_valid <= 1'b0;

        while (ledger.pending() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 20) @(posedge clk);

        $display("Sent %0d events: %0d creates stored, %0d rejected on a full table,",
                 events_sent, ledger.n_created, ledger.n_full);
        $display("%0d destroys matched (%0d with time running backwards), %0d unmatched.",
                 ledger.n_matched, ledger.n_backwards, ledger.n_unmatched);
        if (ledger.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", ledger.failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* allocation_usage_lifetime_tracker.f */
+incdir+rtl/core
rtl/core/ault_pkg.sv
rtl/core/ault_ram.sv
rtl/core/allocation_usage_lifetime_tracker.sv
rtl/core/ault_checker.sv
test/tb.sv
